/* hdl/psue_pkg.sv */
// Shared types and constants for the particle swarm update engine.
// No dependencies.
package psue_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EXEC,
        S_PC_RD,
        S_PC_WR,
        S_GW_RD,
        S_GW_CMP,
        S_GC_RD,
        S_GC_WR,
        S_MUL,
        S_MV_POS,
        S_FRD,
        S_FOUT
    } state_t;

    typedef logic [2:0] op_t;

    localparam op_t OP_COEF   = 3'd0;
    localparam op_t OP_LOAD   = 3'd1;
    localparam op_t OP_SCORE  = 3'd2;
    localparam op_t OP_GLOBAL = 3'd3;
    localparam op_t OP_MOVE   = 3'd4;
    localparam op_t OP_READ   = 3'd5;

    localparam logic CFG_PARTICLES = 1'b0;
    localparam logic CFG_DIMS      = 1'b1;

    localparam logic [31:0] SCORE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN   = 32'h8000_0000;

    // move micro-steps
    localparam logic [3:0] MS_WV    = 4'd0;
    localparam logic [3:0] MS_C1R   = 4'd1;
    localparam logic [3:0] MS_C2R   = 4'd2;
    localparam logic [3:0] MS_P1L   = 4'd3;
    localparam logic [3:0] MS_P1H   = 4'd4;
    localparam logic [3:0] MS_P2L   = 4'd5;
    localparam logic [3:0] MS_P2H   = 4'd6;
    localparam logic [3:0] MS_ACC2  = 4'd7;
    localparam logic [3:0] MS_SUM2  = 4'd8;
    localparam logic [3:0] MS_SAT   = 4'd9;

endpackage

/* hdl/particle_swarm_update_engine.sv */
// Particle swarm update engine: top level, sequencer and storage.
// Depends on psue_pkg.
//
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+----------------------------
// request   | start, busy, operation .. rand_global     | taken when start & !busy
// result    | done, status .. saturated                 | one-cycle strobe on done
// config    | cfg_write, cfg_index, cfg_data            | written when cfg_write high
//
// Coefficient, load and read pass through the readback states to done; score
// also copies the position row to the best position row when it improves;
// global best walks the particles in use and copies a row per improvement;
// move steps the shared 34x18 multiplier through its micro-steps. Element
// memories have one read and one write port. After reset a clearing pass
// zeroes velocities and sets best scores to maximum; busy stays high during it.
// Results cannot be stalled; done is high for one cycle per request.
module particle_swarm_update_engine #(
    parameter int PARTICLES = 32,
    parameter int DIMS      = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [5:0]           cfg_data,
    input  psue_pkg::op_t        operation,
    input  logic [4:0]           particle_index,
    input  logic [2:0]           dim_index,
    input  logic signed [31:0]   position_value,
    input  logic signed [31:0]   velocity_value,
    input  logic signed [15:0]   inertia_coef,
    input  logic signed [15:0]   cognitive_coef,
    input  logic signed [15:0]   social_coef,
    input  logic signed [31:0]   score_value,
    input  logic [15:0]          rand_personal,
    input  logic [15:0]          rand_global,
    output logic                 status,
    output logic signed [31:0]   elem_position,
    output logic signed [31:0]   elem_velocity,
    output logic signed [31:0]   elem_best_position,
    output logic signed [31:0]   particle_best_score,
    output logic                 improved,
    output logic signed [31:0]   swarm_best_score,
    output logic [4:0]           swarm_best_particle,
    output logic signed [31:0]   swarm_best_position,
    output logic                 saturated
);
    import psue_pkg::*;

    localparam int PW   = $clog2(PARTICLES);
    localparam int DW   = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int AW   = PW + DW;
    localparam int PCW  = (PW + 1 > 6) ? PW + 1 : 6;
    localparam int DCW  = (DW + 1 > 4) ? DW + 1 : 4;

    // storage
    logic [31:0] pos_mem  [2**AW];
    logic [31:0] vel_mem  [2**AW];
    logic [31:0] bpos_mem [2**AW];
    logic [31:0] bs_mem   [2**PW];
    logic [31:0] gpos_mem [2**DW];
    logic [47:0] coef_mem [2**DW];

    logic [31:0] pos_rd_reg, vel_rd_reg, bpos_rd_reg, bs_rd_reg, gpos_rd_reg;
    logic [47:0] coef_rd_reg;

    // control state
    state_t           state_reg, state_next;
    logic [5:0]       piu_reg;
    logic [3:0]       diu_reg;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [PCW-1:0]   idx_reg, idx_next;
    logic [3:0]       step_reg, step_next;
    logic [31:0]      swarm_score_reg, swarm_score_next;
    logic [4:0]       swarm_part_reg, swarm_part_next;
    logic             improved_reg, improved_next;
    logic             sat_reg, sat_next;
    logic             done_reg;

    // latched request
    op_t              op_reg;
    logic [4:0]       p_reg;
    logic [2:0]       d_reg;
    logic [31:0]      posin_reg, velin_reg, score_reg;
    logic [47:0]      coefin_reg;
    logic [15:0]      r1_reg, r2_reg;

    // move datapath
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] prod_reg;
    logic signed [32:0] c1r_reg, c1r_next, c2r_reg, c2r_next;
    logic signed [32:0] diff1_reg, diff1_next, diff2_reg, diff2_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [39:0] sum_reg, sum_next;
    logic [31:0]        nv_reg, nv_next;

    // output registers
    logic        status_reg;
    logic [31:0] o_pos_reg, o_vel_reg, o_bpos_reg, o_pbs_reg, o_gpos_reg;

    // memory ports
    logic          pos_we, vel_we, bpos_we, bs_we, gpos_we, coef_we;
    logic [AW-1:0] pos_wa, vel_wa, bpos_wa, pos_ra, bpos_ra;
    logic [31:0]   pos_wd, vel_wd, bpos_wd, bs_wd, gpos_wd;
    logic [PW-1:0] bs_wa, bs_ra;
    logic [DW-1:0] gpos_wa;

    // index checks
    logic [PCW-1:0] pu;
    logic [DCW-1:0] du;
    logic           p_ok, d_ok, e_ok, fail;
    logic [PW-1:0]  p_addr;
    logic [DW-1:0]  d_addr;
    logic [AW-1:0]  e_addr;
    logic           last_dim, walk_last, score_lt, swarm_lt;
    logic signed [39:0] term;
    logic signed [32:0] nx;

    assign pu = (PCW'(piu_reg) > PCW'(PARTICLES)) ? PCW'(PARTICLES) : PCW'(piu_reg);
    assign du = (DCW'(diu_reg) > DCW'(DIMS)) ? DCW'(DIMS) : DCW'(diu_reg);
    assign p_ok = PCW'(p_reg) < pu;
    assign d_ok = DCW'(d_reg) < du;
    assign e_ok = p_ok && d_ok;
    assign p_addr = PW'(p_reg);
    assign d_addr = DW'(d_reg);
    assign e_addr = {p_addr, d_addr};
    assign fail = (op_reg == OP_COEF) ? !d_ok : ((op_reg == OP_GLOBAL) ? 1'b0 : !e_ok);
    assign last_dim  = (cnt_reg == AW'(DIMS - 1));
    assign walk_last = (idx_reg + PCW'(1)) == pu;
    assign score_lt  = $signed(score_reg) < $signed(bs_rd_reg);
    assign swarm_lt  = $signed(bs_rd_reg) < $signed(swarm_score_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piu_reg <= 6'd32;
            diu_reg <= 4'd8;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PARTICLES: piu_reg <= cfg_data;
                CFG_DIMS:      diu_reg <= cfg_data[3:0];
                default:       piu_reg <= piu_reg;
            endcase
        end
    end

    // latch request fields on accept
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg     <= operation;
            p_reg      <= particle_index;
            d_reg      <= dim_index;
            posin_reg  <= position_value;
            velin_reg  <= velocity_value;
            score_reg  <= score_value;
            coefin_reg <= {inertia_coef, cognitive_coef, social_coef};
            r1_reg     <= rand_personal;
            r2_reg     <= rand_global;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (cnt_reg == '1) state_next = S_IDLE;
            S_IDLE:   if (start) state_next = S_RD;
            S_RD:     state_next = S_EXEC;
            S_EXEC:
            begin
                if (fail)
                    state_next = S_FRD;
                else
                begin
                    case (op_reg)
                        OP_SCORE:  state_next = score_lt ? S_PC_RD : S_FRD;
                        OP_GLOBAL: state_next = (pu == '0) ? S_FRD : S_GW_RD;
                        OP_MOVE:   state_next = S_MUL;
                        default:   state_next = S_FRD;
                    endcase
                end
            end
            S_PC_RD:  state_next = S_PC_WR;
            S_PC_WR:  state_next = last_dim ? S_FRD : S_PC_RD;
            S_GW_RD:  state_next = S_GW_CMP;
            S_GW_CMP: state_next = swarm_lt ? S_GC_RD : (walk_last ? S_FRD : S_GW_RD);
            S_GC_RD:  state_next = S_GC_WR;
            S_GC_WR:
            begin
                if (!last_dim)
                    state_next = S_GC_RD;
                else
                    state_next = walk_last ? S_FRD : S_GW_RD;
            end
            S_MUL:    if (step_reg == MS_SAT) state_next = S_MV_POS;
            S_MV_POS: state_next = S_FRD;
            S_FRD:    state_next = S_FOUT;
            S_FOUT:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        case (step_reg)
            MS_WV:
            begin
                mul_a = 34'($signed(vel_rd_reg));
                mul_b = 18'($signed(coef_rd_reg[47:32]));
            end
            MS_C1R:
            begin
                mul_a = $signed({18'd0, r1_reg});
                mul_b = 18'($signed(coef_rd_reg[31:16]));
            end
            MS_C2R:
            begin
                mul_a = $signed({18'd0, r2_reg});
                mul_b = 18'($signed(coef_rd_reg[15:0]));
            end
            MS_P1L:
            begin
                mul_a = 34'(c1r_reg);
                mul_b = $signed({2'b00, diff1_reg[15:0]});
            end
            MS_P1H:
            begin
                mul_a = 34'(c1r_reg);
                mul_b = 18'($signed(diff1_reg[32:16]));
            end
            MS_P2L:
            begin
                mul_a = 34'(c2r_reg);
                mul_b = $signed({2'b00, diff2_reg[15:0]});
            end
            MS_P2H:
            begin
                mul_a = 34'(c2r_reg);
                mul_b = 18'($signed(diff2_reg[32:16]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        swarm_score_next = swarm_score_reg;
        swarm_part_next  = swarm_part_reg;
        improved_next    = improved_reg;
        sat_next         = sat_reg;
        c1r_next         = c1r_reg;
        c2r_next         = c2r_reg;
        diff1_next       = diff1_reg;
        diff2_next       = diff2_reg;
        acc_next         = acc_reg;
        sum_next         = sum_reg;
        nv_next          = nv_reg;
        term             = '0;
        nx               = '0;

        pos_we  = 1'b0;  pos_wa  = e_addr;  pos_wd  = posin_reg;  pos_ra  = e_addr;
        vel_we  = 1'b0;  vel_wa  = e_addr;  vel_wd  = velin_reg;
        bpos_we = 1'b0;  bpos_wa = e_addr;  bpos_wd = posin_reg;  bpos_ra = e_addr;
        bs_we   = 1'b0;  bs_wa   = p_addr;  bs_wd   = score_reg;  bs_ra   = p_addr;
        gpos_we = 1'b0;  gpos_wa = cnt_reg[DW-1:0];  gpos_wd = bpos_rd_reg;
        coef_we = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                vel_we   = 1'b1;
                vel_wa   = cnt_reg;
                vel_wd   = '0;
                bs_we    = 1'b1;
                bs_wa    = cnt_reg[PW-1:0];
                bs_wd    = SCORE_MAX;
                cnt_next = cnt_reg + AW'(1);
            end
            S_IDLE:
            begin
                improved_next = 1'b0;
                sat_next      = 1'b0;
                cnt_next      = '0;
                idx_next      = '0;
                step_next     = MS_WV;
            end
            S_EXEC:
            begin
                diff1_next = 33'($signed(bpos_rd_reg)) - 33'($signed(pos_rd_reg));
                diff2_next = 33'($signed(gpos_rd_reg)) - 33'($signed(pos_rd_reg));
                if (!fail)
                begin
                    case (op_reg)
                        OP_COEF: coef_we = 1'b1;
                        OP_LOAD:
                        begin
                            pos_we  = 1'b1;
                            bpos_we = 1'b1;
                            vel_we  = 1'b1;
                        end
                        OP_SCORE:
                        begin
                            if (score_lt)
                            begin
                                bs_we         = 1'b1;
                                improved_next = 1'b1;
                            end
                        end
                        default: improved_next = improved_reg;
                    endcase
                end
            end
            // personal best copy: position row -> best position row
            S_PC_RD:
            begin
                pos_ra = {p_addr, cnt_reg[DW-1:0]};
            end
            S_PC_WR:
            begin
                bpos_we  = 1'b1;
                bpos_wa  = {p_addr, cnt_reg[DW-1:0]};
                bpos_wd  = pos_rd_reg;
                cnt_next = cnt_reg + AW'(1);
            end
            // swarm best walk
            S_GW_RD:
            begin
                bs_ra = idx_reg[PW-1:0];
            end
            S_GW_CMP:
            begin
                cnt_next = '0;
                if (swarm_lt)
                begin
                    swarm_score_next = bs_rd_reg;
                    swarm_part_next  = 5'(idx_reg);
                    improved_next    = 1'b1;
                end
                else
                    idx_next = idx_reg + PCW'(1);
            end
            S_GC_RD:
            begin
                bpos_ra = {idx_reg[PW-1:0], cnt_reg[DW-1:0]};
            end
            S_GC_WR:
            begin
                gpos_we  = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (last_dim)
                    idx_next = idx_reg + PCW'(1);
            end
            // move: one product per cycle, accumulate the next cycle
            S_MUL:
            begin
                step_next = step_reg + 4'd1;
                case (step_reg)
                    MS_C1R:  sum_next = 40'(prod_reg >>> 12);
                    MS_C2R:  c1r_next = prod_reg[32:0];
                    MS_P1L:  c2r_next = prod_reg[32:0];
                    MS_P1H:  acc_next = 66'(prod_reg);
                    MS_P2L:  acc_next = acc_reg + (66'(prod_reg) <<< 16);
                    MS_P2H:
                    begin
                        sum_next = sum_reg + 40'(acc_reg >>> 28);
                        acc_next = 66'(prod_reg);
                    end
                    MS_ACC2: acc_next = acc_reg + (66'(prod_reg) <<< 16);
                    MS_SUM2: sum_next = sum_reg + 40'(acc_reg >>> 28);
                    MS_SAT:
                    begin
                        term = sum_reg;
                        if (term > 40'($signed(VAL_MAX)))
                        begin
                            nv_next  = VAL_MAX;
                            sat_next = 1'b1;
                        end
                        else if (term < 40'($signed(VAL_MIN)))
                        begin
                            nv_next  = VAL_MIN;
                            sat_next = 1'b1;
                        end
                        else
                            nv_next = term[31:0];
                        vel_we = 1'b1;
                        vel_wd = nv_next;
                    end
                    default: step_next = step_reg + 4'd1;
                endcase
            end
            S_MV_POS:
            begin
                nx     = 33'($signed(pos_rd_reg)) + 33'($signed(nv_reg));
                pos_we = 1'b1;
                if (nx[32] != nx[31])
                begin
                    sat_next = 1'b1;
                    pos_wd   = nx[32] ? VAL_MIN : VAL_MAX;
                end
                else
                    pos_wd = nx[31:0];
            end
            default: cnt_next = cnt_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            idx_reg         <= '0;
            step_reg        <= MS_WV;
            swarm_score_reg <= SCORE_MAX;
            swarm_part_reg  <= '0;
            improved_reg    <= 1'b0;
            sat_reg         <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            idx_reg         <= idx_next;
            step_reg        <= step_next;
            swarm_score_reg <= swarm_score_next;
            swarm_part_reg  <= swarm_part_next;
            improved_reg    <= improved_next;
            sat_reg         <= sat_next;
            done_reg        <= (state_reg == S_FOUT);
        end
    end

    // move datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        c1r_reg   <= c1r_next;
        c2r_reg   <= c2r_next;
        diff1_reg <= diff1_next;
        diff2_reg <= diff2_next;
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        nv_reg    <= nv_next;
    end

    // result registers, loaded from the readback
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FOUT)
        begin
            status_reg <= fail;
            o_pos_reg  <= e_ok ? pos_rd_reg  : '0;
            o_vel_reg  <= e_ok ? vel_rd_reg  : '0;
            o_bpos_reg <= e_ok ? bpos_rd_reg : '0;
            o_pbs_reg  <= e_ok ? bs_rd_reg   : '0;
            o_gpos_reg <= d_ok ? gpos_rd_reg : '0;
        end
    end

    // element memories
    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_wa] <= pos_wd;
        pos_rd_reg <= pos_mem[pos_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vel_we)
            vel_mem[vel_wa] <= vel_wd;
        vel_rd_reg <= vel_mem[e_addr];
    end

    always_ff @(posedge clk)
    begin
        if (bpos_we)
            bpos_mem[bpos_wa] <= bpos_wd;
        bpos_rd_reg <= bpos_mem[bpos_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bs_we)
            bs_mem[bs_wa] <= bs_wd;
        bs_rd_reg <= bs_mem[bs_ra];
    end

    always_ff @(posedge clk)
    begin
        if (gpos_we)
            gpos_mem[gpos_wa] <= gpos_wd;
        gpos_rd_reg <= gpos_mem[d_addr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[d_addr] <= coefin_reg;
        coef_rd_reg <= coef_mem[d_addr];
    end

    // ports
    assign busy                = (state_reg != S_IDLE);
    assign done                = done_reg;
    assign status              = status_reg;
    assign elem_position       = o_pos_reg;
    assign elem_velocity       = o_vel_reg;
    assign elem_best_position  = o_bpos_reg;
    assign particle_best_score = o_pbs_reg;
    assign improved            = improved_reg;
    assign saturated           = sat_reg;
    assign swarm_best_score    = swarm_score_reg;
    assign swarm_best_particle = swarm_part_reg;
    assign swarm_best_position = o_gpos_reg;

endmodule

/* hdl/psue_checker.sv */
// Port-level checks for the particle swarm update engine, bound to the top.
// Depends on particle_swarm_update_engine.
module psue_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic status,
    input logic improved,
    input logic saturated
);

    // a result shows only once the engine is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    // an accepted request makes the engine busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request accepted but not busy");

    // one strobe per request
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");

    // a rejected request changes nothing
    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (!improved && !saturated))
        else $error("rejected request reports a change");

endmodule

bind particle_swarm_update_engine psue_checker u_psue_checker (.*);
